>>> src/cppb_pkg.sv
// Package for the clipped packed-pixel blitter.
// Holds the register file type, register and depth codes, and reset values.
// No dependencies.
package cppb_pkg;

  // Pixel depth codes; the two unused codes behave as 24 bpp
  typedef enum logic [2:0] {
    DEPTH_1BPP  = 3'd0,
    DEPTH_2BPP  = 3'd1,
    DEPTH_4BPP  = 3'd2,
    DEPTH_8BPP  = 3'd3,
    DEPTH_16BPP = 3'd4,
    DEPTH_24BPP = 3'd5
  } depth_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_COLOR_DEPTH   = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_WINDOW_LEFT   = 3'd3,
    REG_WINDOW_TOP    = 3'd4,
    REG_WINDOW_WIDTH  = 3'd5,
    REG_WINDOW_HEIGHT = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PixW     = 24;
  localparam int unsigned AddrOutW = 22;
  // Widest clamped dimension (largest allowed maximum is 4096)
  localparam int unsigned ClampW   = 13;

  typedef struct packed {
    logic [2:0]         color_depth;
    logic [10:0]        screen_width;
    logic [10:0]        screen_height;
    logic signed [15:0] window_left;
    logic signed [15:0] window_top;
    logic [10:0]        window_width;
    logic [10:0]        window_height;
  } cfg_t;

  localparam logic [2:0]  ResetColorDepth  = DEPTH_8BPP;
  localparam logic [10:0] ResetScreenWidth  = 11'd320;
  localparam logic [10:0] ResetScreenHeight = 11'd240;

  // Limit a dimension register to the configured maximum
  function automatic logic [ClampW-1:0] clamp_dim(logic [10:0] v, logic [ClampW-1:0] lim);
    logic [ClampW-1:0] ext;
    ext = {2'b00, v};
    return (ext > lim) ? lim : ext;
  endfunction

  // Bits of the pixel kept for a depth code
  function automatic logic [PixW-1:0] value_mask(logic [2:0] d);
    logic [PixW-1:0] m;
    unique case (d)
      DEPTH_1BPP:  m = 24'h000001;
      DEPTH_2BPP:  m = 24'h000003;
      DEPTH_4BPP:  m = 24'h00000f;
      DEPTH_8BPP:  m = 24'h0000ff;
      DEPTH_16BPP: m = 24'h00ffff;
      default:     m = 24'hffffff;
    endcase
    return m;
  endfunction

  // Bytes per pixel, one for the sub-byte modes
  function automatic logic [1:0] bytes_per_pixel(logic [2:0] d);
    logic [1:0] c;
    unique case (d)
      DEPTH_1BPP, DEPTH_2BPP, DEPTH_4BPP, DEPTH_8BPP: c = 2'd1;
      DEPTH_16BPP: c = 2'd2;
      default:     c = 2'd3;
    endcase
    return c;
  endfunction

endpackage

>>> src/cppb_cfg.sv
// Configuration register file of the blitter.
// Depends on cppb_pkg (cfg_t, register indexes, reset values).
module cppb_cfg import cppb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Writes are always accepted and never stall
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_depth   <= ResetColorDepth;
      cfg_q.screen_width  <= ResetScreenWidth;
      cfg_q.screen_height <= ResetScreenHeight;
      cfg_q.window_left   <= '0;
      cfg_q.window_top    <= '0;
      cfg_q.window_width  <= '0;
      cfg_q.window_height <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COLOR_DEPTH:   cfg_q.color_depth   <= cfg_data_i[2:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[10:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[10:0];
        REG_WINDOW_LEFT:   cfg_q.window_left   <= $signed(cfg_data_i);
        REG_WINDOW_TOP:    cfg_q.window_top    <= $signed(cfg_data_i);
        REG_WINDOW_WIDTH:  cfg_q.window_width  <= cfg_data_i[10:0];
        REG_WINDOW_HEIGHT: cfg_q.window_height <= cfg_data_i[10:0];
        default: ;  // index beyond the register list: dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/cppb_place.sv
// Placement stage: source column/row counters, window offset and screen clip,
// registered into the stage register. Depends on cppb_pkg.
module cppb_place import cppb_pkg::*; #(
  parameter int unsigned MaxDim = 1024,
  parameter int unsigned CntW   = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            fire_i,       // input transaction taken
  input  logic            load_i,       // stage register may be loaded
  input  logic [PixW-1:0] pixel_i,
  output logic            valid_o,
  output logic            we_o,
  output logic            last_o,
  output logic [CntW-1:0] dx_o,
  output logic [CntW-1:0] dy_o,
  output logic [PixW-1:0] pixel_o
);

  localparam int unsigned DimW = CntW + 1;
  localparam int unsigned PosW = ((CntW > 16) ? CntW : 16) + 2;

  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic            valid_q, we_q, last_q;
  logic [CntW-1:0] dx_q, dy_q;
  logic [PixW-1:0] pix_q;

  logic [DimW-1:0] sw, sh, ww, wh;
  logic signed [PosW-1:0] dx, dy;
  logic empty, col_wrap, row_wrap, on_screen, last;

  // Clamped dimensions
  assign sw = DimW'(clamp_dim(cfg_i.screen_width,  ClampW'(MaxDim)));
  assign sh = DimW'(clamp_dim(cfg_i.screen_height, ClampW'(MaxDim)));
  assign ww = DimW'(clamp_dim(cfg_i.window_width,  ClampW'(MaxDim)));
  assign wh = DimW'(clamp_dim(cfg_i.window_height, ClampW'(MaxDim)));

  // Screen position and clip
  assign dx = PosW'(cfg_i.window_left) + $signed({{(PosW-CntW){1'b0}}, col_q});
  assign dy = PosW'(cfg_i.window_top)  + $signed({{(PosW-CntW){1'b0}}, row_q});
  assign empty     = (ww == '0) || (wh == '0);
  assign on_screen = !empty && !dx[PosW-1] && !dy[PosW-1]
                     && ($unsigned(dx) < PosW'(sw)) && ($unsigned(dy) < PosW'(sh));

  // Raster counters
  assign col_wrap = (DimW'(col_q) + DimW'(1)) >= ww;
  assign row_wrap = (DimW'(row_q) + DimW'(1)) >= wh;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    last  = 1'b0;
    if (empty) begin
      col_d = '0;
      row_d = '0;
      last  = 1'b1;
    end else if (col_wrap) begin
      col_d = '0;
      if (row_wrap) begin
        row_d = '0;
        last  = 1'b1;
      end else begin
        row_d = row_q + CntW'(1);
      end
    end else begin
      col_d = col_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (fire_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (load_i) begin
        valid_q <= fire_i;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      we_q   <= on_screen;
      last_q <= last;
      dx_q   <= dx[CntW-1:0];
      dy_q   <= dy[CntW-1:0];
      pix_q  <= pixel_i & value_mask(cfg_i.color_depth);
    end
  end

  assign valid_o = valid_q;
  assign we_o    = we_q;
  assign last_o  = last_q;
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;
  assign pixel_o = pix_q;

endmodule

>>> src/cppb_addr.sv
// Address stage: linear pixel index, byte address, shift and mask,
// registered into the result register. Depends on cppb_pkg.
module cppb_addr import cppb_pkg::*; #(
  parameter int unsigned MaxDim = 1024,
  parameter int unsigned CntW   = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                adv_i,       // result register may be loaded
  input  logic                valid_i,
  input  logic                we_i,
  input  logic                last_i,
  input  logic [CntW-1:0]     dx_i,
  input  logic [CntW-1:0]     dy_i,
  input  logic [PixW-1:0]     pixel_i,
  output logic                valid_o,
  output logic                write_enable_o,
  output logic [AddrOutW-1:0] byte_address_o,
  output logic [2:0]          bit_shift_o,
  output logic [7:0]          bit_mask_o,
  output logic [PixW-1:0]     pixel_bits_o,
  output logic [1:0]          byte_count_o,
  output logic                last_pixel_o
);

  localparam int unsigned DimW  = CntW + 1;
  localparam int unsigned ProdW = CntW + DimW;
  localparam int unsigned IdxW  = 2 * CntW;
  localparam int unsigned AddrW = IdxW + 2;

  logic [DimW-1:0]  sw;
  logic [ProdW-1:0] prod;
  logic [IdxW-1:0]  idx;
  logic [AddrW-1:0] addr;
  logic [2:0]       shift;
  logic [7:0]       mask;
  logic [7:0]       vmask;

  logic                valid_q, we_q, last_q;
  logic [AddrOutW-1:0] addr_q;
  logic [2:0]          shift_q;
  logic [7:0]          mask_q;
  logic [PixW-1:0]     pix_q;
  logic [1:0]          count_q;

  assign sw    = DimW'(clamp_dim(cfg_i.screen_width, ClampW'(MaxDim)));
  assign prod  = ProdW'(dy_i) * ProdW'(sw) + ProdW'(dx_i);
  assign idx   = prod[IdxW-1:0];
  assign vmask = 8'(value_mask(cfg_i.color_depth));

  // Byte address and in-byte placement per depth (MSB-first packing)
  always_comb begin
    addr  = '0;
    shift = '0;
    mask  = 8'hff;
    unique case (cfg_i.color_depth)
      DEPTH_1BPP: begin
        addr  = AddrW'(idx >> 3);
        shift = ~idx[2:0];
      end
      DEPTH_2BPP: begin
        addr  = AddrW'(idx >> 2);
        shift = {~idx[1:0], 1'b0};
      end
      DEPTH_4BPP: begin
        addr  = AddrW'(idx >> 1);
        shift = {~idx[0], 2'b00};
      end
      DEPTH_8BPP:  addr = AddrW'(idx);
      DEPTH_16BPP: addr = {idx, 1'b0} & AddrW'({(IdxW+1){1'b1}});
      default:     addr = AddrW'(idx) + AddrW'({idx, 1'b0});
    endcase
    if (shift != '0 || cfg_i.color_depth == DEPTH_1BPP || cfg_i.color_depth == DEPTH_2BPP
        || cfg_i.color_depth == DEPTH_4BPP) begin
      mask = 8'(vmask << shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Result payload; clipped pixels give zero placement
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      we_q    <= we_i;
      last_q  <= last_i;
      addr_q  <= we_i ? AddrOutW'(addr) : '0;
      shift_q <= we_i ? shift : '0;
      mask_q  <= we_i ? mask : '0;
      pix_q   <= pixel_i;
      count_q <= bytes_per_pixel(cfg_i.color_depth);
    end
  end

  assign valid_o        = valid_q;
  assign write_enable_o = we_q;
  assign byte_address_o = addr_q;
  assign bit_shift_o    = shift_q;
  assign bit_mask_o     = mask_q;
  assign pixel_bits_o   = pix_q;
  assign byte_count_o   = count_q;
  assign last_pixel_o   = last_q;

endmodule

>>> src/clipped_packed_pixel_blitter_core.sv
// Top level of the clipped packed-pixel blitter.
// Depends on cppb_pkg, cppb_cfg, cppb_place and cppb_addr.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o  | source_pixel_i
//   out     | source    | out_valid_o / out_stall_i| write_enable_o .. last_pixel_o
//   cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One pixel per clock while the output is not stalled; a transaction passes the
// placement/clip register, then index multiply and result register, to be offered.
// Reset (async, active low) clears the counters, the pipeline and the registers
// to their defaults. A stalled output holds both stages; in_stall_o rises only
// when both stages are full and the output is stalled. Config writes never stall.
module clipped_packed_pixel_blitter_core import cppb_pkg::*; #(
  parameter int unsigned MAX_DIMENSION = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixW-1:0]     source_pixel_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                write_enable_o,
  output logic [AddrOutW-1:0] byte_address_o,
  output logic [2:0]          bit_shift_o,
  output logic [7:0]          bit_mask_o,
  output logic [PixW-1:0]     pixel_bits_o,
  output logic [1:0]          byte_count_o,
  output logic                last_pixel_o
);

  localparam int unsigned CntW = $clog2(MAX_DIMENSION);

  cfg_t            cfg;
  logic            adv, load_a, fire;
  logic            valid_a, we_a, last_a;
  logic [CntW-1:0] dx_a, dy_a;
  logic [PixW-1:0] pix_a;

  // Pipeline advance control
  assign adv        = !(out_valid_o && out_stall_i);
  assign load_a     = !valid_a || adv;
  assign in_stall_o = !load_a;
  assign fire       = in_valid_i && load_a;

  cppb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cppb_place #(
    .MaxDim (MAX_DIMENSION),
    .CntW   (CntW)
  ) u_place (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .fire_i  (fire),
    .load_i  (load_a),
    .pixel_i (source_pixel_i),
    .valid_o (valid_a),
    .we_o    (we_a),
    .last_o  (last_a),
    .dx_o    (dx_a),
    .dy_o    (dy_a),
    .pixel_o (pix_a)
  );

  cppb_addr #(
    .MaxDim (MAX_DIMENSION),
    .CntW   (CntW)
  ) u_addr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .adv_i          (adv),
    .valid_i        (valid_a),
    .we_i           (we_a),
    .last_i         (last_a),
    .dx_i           (dx_a),
    .dy_i           (dy_a),
    .pixel_i        (pix_a),
    .valid_o        (out_valid_o),
    .write_enable_o (write_enable_o),
    .byte_address_o (byte_address_o),
    .bit_shift_o    (bit_shift_o),
    .bit_mask_o     (bit_mask_o),
    .pixel_bits_o   (pixel_bits_o),
    .byte_count_o   (byte_count_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

>>> src/cppb_checker.sv
// Port-level checker for the blitter, bound to the top level.
// Depends on cppb_pkg and clipped_packed_pixel_blitter_core.
module cppb_checker import cppb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                write_enable_o,
  input logic [AddrOutW-1:0] byte_address_o,
  input logic [2:0]          bit_shift_o,
  input logic [7:0]          bit_mask_o,
  input logic [1:0]          byte_count_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its address and mask
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(byte_address_o) && $stable(bit_mask_o))
    else $error("stalled result changed");

  // Clipped pixels carry no placement
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |->
      byte_address_o == '0 && bit_shift_o == '0 && bit_mask_o == '0)
    else $error("clipped pixel with placement");

  // Multi-byte pixels replace whole bytes
  a_wide_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o && byte_count_o != 2'd1 |->
      bit_mask_o == 8'hff && bit_shift_o == '0)
    else $error("multi-byte pixel with partial mask");

  // Input is only held off when a result is waiting under stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

endmodule

bind clipped_packed_pixel_blitter_core cppb_checker u_cppb_checker (.*);
